/* sv/tgr_pkg.sv */
// Shared types and constants for the text glyph renderer.
`default_nettype none

package tgr_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 160;
    localparam int GLYPH_COUNT_DEF   = 256;

    // Glyph layout
    localparam int GLYPH_COLS = 5;
    localparam logic [2:0] LAST_COL = 3'd5;   // blank spacing column
    localparam logic [2:0] LAST_ROW = 3'd7;

    // Widths
    localparam int COORD_W     = 12;   // x/y while drawing, covers cursor + 7*255
    localparam int COL_W       = 12;
    localparam int ROW_W       = 16;
    localparam int FONT_ADDR_W = 11;

    // Input op codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CURSOR = 2'd1;
    localparam logic [1:0] OP_PRINT  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_SCALE = 2'd0;
    localparam logic [1:0] REG_FG    = 2'd1;
    localparam logic [1:0] REG_BG    = 2'd2;

    localparam logic [7:0] CHAR_NL = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    typedef struct packed {
        logic [15:0] color;
        logic [7:0]  h;
        logic [7:0]  w;
        logic [7:0]  y;
        logic [6:0]  x;
    } rect_t;

    typedef struct packed {
        logic                   code_ok;
        logic [COORD_W-1:0]     x0;
        logic [COORD_W-1:0]     y0;
        logic [7:0]             scale;
        logic [FONT_ADDR_W-1:0] base;
    } start_t;

endpackage

`default_nettype wire

/* sv/tgr_glyph_mem.sv */
// Font store: one write port, one registered read port.
`default_nettype none

module tgr_glyph_mem #(
    parameter int DEPTH  = tgr_pkg::GLYPH_COUNT_DEF * tgr_pkg::GLYPH_COLS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/tgr_raster.sv */
// Glyph scan: walks six columns by eight rows and emits clipped rectangles.
`default_nettype none

module tgr_raster #(
    parameter int SCREEN_WIDTH  = tgr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tgr_pkg::SCREEN_HEIGHT_DEF,
    parameter int ADDR_W        = 11
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire tgr_pkg::start_t        start_cmd,
    input  wire logic [15:0]            fg,
    input  wire logic [15:0]            bg,
    output logic                        done,
    output logic                        rd_en,
    output logic      [ADDR_W-1:0]      rd_addr,
    input  wire logic [7:0]             rd_data,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [47:0]            m_tdata,
    output logic                        m_tlast
);

    localparam int CW = tgr_pkg::COORD_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_ROWS  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [2:0]      col_reg, col_next;
    logic [2:0]      row_reg, row_next;
    logic [CW-1:0]   x_reg, x_next;
    logic [CW-1:0]   y_reg, y_next;
    tgr_pkg::start_t cmd_reg;
    tgr_pkg::rect_t  pend_reg;
    logic            pend_valid_reg, pend_valid_next;
    tgr_pkg::rect_t  out_rect_reg;
    logic            out_last_reg;
    logic            out_valid_reg, out_valid_next;

    logic [7:0]      line;
    logic            pix;
    logic            cand_en;
    tgr_pkg::rect_t  cand;
    logic [CW:0]     x_end;
    logic [CW:0]     y_end;
    logic            out_free;
    logic            step;
    logic            push_mid;
    logic            flush_push;
    logic [2:0]      rd_col;

    always_comb
    begin
        line = (col_reg == tgr_pkg::LAST_COL || !cmd_reg.code_ok) ? 8'd0 : rd_data;
        pix  = line[row_reg];

        x_end = {1'b0, x_reg} + (CW+1)'(cmd_reg.scale);
        y_end = {1'b0, y_reg} + (CW+1)'(cmd_reg.scale);

        cand.x     = x_reg[6:0];
        cand.y     = y_reg[7:0];
        cand.color = pix ? fg : bg;
        if (x_end > (CW+1)'(SCREEN_WIDTH))
        begin
            cand.w = 8'(CW'(SCREEN_WIDTH) - x_reg);
        end
        else
        begin
            cand.w = cmd_reg.scale;
        end
        if (y_end > (CW+1)'(SCREEN_HEIGHT))
        begin
            cand.h = 8'(CW'(SCREEN_HEIGHT) - y_reg);
        end
        else
        begin
            cand.h = cmd_reg.scale;
        end

        cand_en = (state_reg == ST_ROWS) && (pix || (fg != bg))
                  && (x_reg < CW'(SCREEN_WIDTH)) && (y_reg < CW'(SCREEN_HEIGHT));

        out_free   = !out_valid_reg || m_tready;
        // the held rectangle leaves once a later one proves it is not the last, or in flush as the last
        step       = (state_reg == ST_ROWS) && (!cand_en || !pend_valid_reg || out_free);
        push_mid   = step && cand_en && pend_valid_reg;
        flush_push = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;
        done       = (state_reg == ST_FLUSH) && (!pend_valid_reg || out_free);

        // prefetch the next column during the last row of this one
        rd_en   = (state_reg == ST_FETCH)
                  || (step && row_reg == tgr_pkg::LAST_ROW && col_reg < 3'd4);
        rd_col  = (state_reg == ST_FETCH) ? 3'd0 : col_reg + 3'd1;
        rd_addr = ADDR_W'(cmd_reg.base) + ADDR_W'(rd_col);
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_FETCH;
                    col_next   = 3'd0;
                    row_next   = 3'd0;
                    x_next     = start_cmd.x0;
                    y_next     = start_cmd.y0;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_ROWS;
            end
            ST_ROWS:
            begin
                if (step)
                begin
                    if (row_reg == tgr_pkg::LAST_ROW)
                    begin
                        row_next = 3'd0;
                        y_next   = cmd_reg.y0;
                        x_next   = x_reg + CW'(cmd_reg.scale);
                        if (col_reg == tgr_pkg::LAST_COL)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            col_next = col_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        row_next = row_reg + 3'd1;
                        y_next   = y_reg + CW'(cmd_reg.scale);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (step && cand_en)
        begin
            pend_valid_next = 1'b1;
        end
        else if (flush_push)
        begin
            pend_valid_next = 1'b0;
        end

        if (push_mid || flush_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= 3'd0;
            row_reg        <= 3'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg <= start_cmd;
        end
        if (step && cand_en)
        begin
            pend_reg <= cand;
        end
        if (push_mid || flush_push)
        begin
            out_rect_reg <= pend_reg;
            out_last_reg <= flush_push;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_rect_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("held rectangle left behind after a character");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= tgr_pkg::LAST_COL)
        else $error("glyph column index past the spacing column");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (push_mid || flush_push) |-> out_free)
        else $error("output register loaded while its item is untaken");
`endif

endmodule

`default_nettype wire

/* sv/text_glyph_renderer.sv */
// Top level: configuration, text cursor, font store and glyph scan.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser op; s_tdata code, cursor, font write
//  m_*     | out | m_tvalid/m_tready  | m_tdata rectangle; m_tlast last of character
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// Font load, cursor set, newline, carriage return and off-screen characters leave
// s_tready high. A drawn character holds s_tready low through one font read, the
// 6 x 8 pixel scan with the next column read overlapped, and a flush of the held
// last rectangle; the next item is taken in the cycle after. Output stalls hold
// the scan.
// Reset clears the cursor, sets scale to 1 and both colors to FFFF; the font store must be loaded.
`default_nettype none

module text_glyph_renderer #(
    parameter int SCREEN_WIDTH  = tgr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tgr_pkg::SCREEN_HEIGHT_DEF,
    parameter int GLYPH_COUNT   = tgr_pkg::GLYPH_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // char_code, set_col, set_row, font_address, font_byte
    input  wire logic [1:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // rect_x, rect_y, rect_w, rect_h, fill_color
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int GLYPH_DEPTH = GLYPH_COUNT * tgr_pkg::GLYPH_COLS;
    localparam int ADDR_W      = $clog2(GLYPH_DEPTH);
    localparam int CW          = tgr_pkg::COL_W;
    localparam int RW          = tgr_pkg::ROW_W;

    logic [7:0]    scale_reg;
    logic [15:0]   fg_reg;
    logic [15:0]   bg_reg;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic          busy_reg, busy_next;

    logic          accept;
    logic [1:0]    op;
    logic [7:0]    char_code;
    logic [6:0]    set_col;
    logic [7:0]    set_row;
    logic [10:0]   font_address;
    logic [7:0]    font_byte;

    logic [7:0]    s_eff;
    logic [10:0]   s6;
    logic [10:0]   s8;
    logic [RW:0]   row_sum;
    logic [RW-1:0] row_adv;
    logic [CW:0]   col_sum;
    logic [CW-1:0] col_new;
    logic          wrap;
    logic [CW-1:0] adv_col;
    logic [RW-1:0] adv_row;
    logic          on_screen;

    logic            start;
    tgr_pkg::start_t start_cmd;
    logic            done;
    logic            mem_we;
    logic            rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]      rd_data;

    assign op           = s_tuser;
    assign char_code    = s_tdata[7:0];
    assign set_col      = s_tdata[14:8];
    assign set_row      = s_tdata[22:15];
    assign font_address = s_tdata[33:23];
    assign font_byte    = s_tdata[41:34];

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        s_eff   = (scale_reg == 8'd0) ? 8'd1 : scale_reg;
        s6      = {1'b0, s_eff, 2'b00} + {2'b00, s_eff, 1'b0};
        s8      = {s_eff, 3'b000};
        row_sum = {1'b0, cur_row_reg} + (RW+1)'(s8);
        row_adv = row_sum[RW] ? {RW{1'b1}} : row_sum[RW-1:0];
        col_sum = {1'b0, cur_col_reg} + (CW+1)'(s6);
        col_new = col_sum[CW-1:0];
        // wrap when the next cell would not fit: col_new > width - 6*scale
        wrap    = ({2'b00, col_new} + (CW+2)'(s6)) > (CW+2)'(SCREEN_WIDTH);
        adv_col = wrap ? '0 : col_new;
        adv_row = wrap ? row_adv : cur_row_reg;
        on_screen = (cur_col_reg < CW'(SCREEN_WIDTH)) && (cur_row_reg < RW'(SCREEN_HEIGHT));

        start_cmd.code_ok = {1'b0, char_code} < 9'(GLYPH_COUNT);
        start_cmd.x0      = cur_col_reg;
        start_cmd.y0      = cur_row_reg[tgr_pkg::COORD_W-1:0];
        start_cmd.scale   = s_eff;
        start_cmd.base    = {3'b000, char_code} + {1'b0, char_code, 2'b00};

        mem_we = accept && (op == tgr_pkg::OP_LOAD)
                 && (font_address < tgr_pkg::FONT_ADDR_W'(GLYPH_DEPTH));
    end

    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        busy_next    = busy_reg;
        start        = 1'b0;

        if (accept)
        begin
            unique case (op)
                tgr_pkg::OP_LOAD:
                begin
                end
                tgr_pkg::OP_CURSOR:
                begin
                    cur_col_next = CW'(set_col);
                    cur_row_next = RW'(set_row);
                end
                tgr_pkg::OP_PRINT:
                begin
                    if (char_code == tgr_pkg::CHAR_NL)
                    begin
                        cur_col_next = '0;
                        cur_row_next = row_adv;
                    end
                    else if (char_code == tgr_pkg::CHAR_CR)
                    begin
                    end
                    else if (on_screen)
                    begin
                        start     = 1'b1;
                        busy_next = 1'b1;
                    end
                    else
                    begin
                        cur_col_next = adv_col;
                        cur_row_next = adv_row;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (done)
        begin
            cur_col_next = adv_col;
            cur_row_next = adv_row;
            busy_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= 8'd1;
            fg_reg      <= 16'hFFFF;
            bg_reg      <= 16'hFFFF;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            busy_reg    <= busy_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tgr_pkg::REG_SCALE: scale_reg <= cfg_data[7:0];
                    tgr_pkg::REG_FG:    fg_reg    <= cfg_data;
                    tgr_pkg::REG_BG:    bg_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    tgr_glyph_mem #(
        .DEPTH  (GLYPH_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_glyph_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (font_address[ADDR_W-1:0]),
        .wdata (font_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tgr_raster #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ADDR_W        (ADDR_W)
    ) u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_cmd (start_cmd),
        .fg        (fg_reg),
        .bg        (bg_reg),
        .done      (done),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("scan finished a character that was never started");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("character started without holding off the input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output item changed while waiting");
`endif

endmodule

`default_nettype wire
